FILE: rtl/lebc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Line edit buffer package
// Command codes, cell operations and shared types of the line edit buffer.
// ---------------------------------------------------------------------------
package lebc_pkg;

  localparam int LINE_CAPACITY_DEF = 64;

  localparam int CMD_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int OFF_W   = 8;
  localparam int POS_W   = 6;
  localparam int FIELD_W = 7;

  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_BACKSPACE = 4'd3;
  localparam logic [CMD_W-1:0] CMD_LEFT      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RIGHT     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_PREV_DIST = 4'd7;
  localparam logic [CMD_W-1:0] CMD_NEXT_DIST = 4'd8;
  localparam logic [CMD_W-1:0] CMD_READ_POS  = 4'd9;

  localparam logic [1:0] CELL_HOLD       = 2'd0;
  localparam logic [1:0] CELL_FROM_LEFT  = 2'd1;
  localparam logic [1:0] CELL_FROM_RIGHT = 2'd2;
  localparam logic [1:0] CELL_LOAD       = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] din;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/lebc_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Line edit buffer channels
// Command channel and result channel, each with valid, ready and payload.
// ---------------------------------------------------------------------------
interface lebc_req_if;
  import lebc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [BYTE_W-1:0]        char_in;
  logic signed [OFF_W-1:0]  offset;
  logic [POS_W-1:0]         position;

  modport source (output valid, cmd, char_in, offset, position, input ready);
  modport sink   (input valid, cmd, char_in, offset, position, output ready);
endinterface

interface lebc_rsp_if;
  import lebc_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [BYTE_W-1:0]  char_out;
  logic [FIELD_W-1:0] distance;
  logic [FIELD_W-1:0] cursor_pos;
  logic [FIELD_W-1:0] line_length;
  logic               at_base;
  logic               at_end;
  logic               is_full_flag;

  modport source (output valid, accepted, char_out, distance, cursor_pos, line_length,
                  at_base, at_end, is_full_flag, input ready);
  modport sink   (input valid, accepted, char_out, distance, cursor_pos, line_length,
                  at_base, at_end, is_full_flag, output ready);
endinterface
`default_nettype wire

FILE: rtl/line_edit_buffer_with_cursor.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Line edit buffer with cursor
// Line store built as a ring of byte cells, with cursor, edits and queries.
//
//   channel | dir | payload
//   req     | in  | cmd, char_in, offset, position
//   rsp     | out | accepted, char_out, distance, cursor_pos, line_length,
//           |     | at_base, at_end, is_full_flag
//
// Edits and cursor moves pass through the exec and done states from accept
// to result: the cells shift toward a neighbor in one parallel step. Queries
// add a scan state in which the ring rotates once while cell 0 is watched.
// One item is in work at a time; req.ready is high only when idle, and a
// waiting result does not block the next accept. Reset clears cursor and
// length; the cell contents are undefined until written.
// ---------------------------------------------------------------------------
module line_edit_buffer_with_cursor #(
  parameter int LINE_CAPACITY = lebc_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lebc_req_if.sink   req,
  lebc_rsp_if.source rsp
);
  import lebc_pkg::*;

  localparam int CW = $clog2(LINE_CAPACITY + 1);
  localparam int TW = ((CW > OFF_W) ? CW : OFF_W) + 2;
  localparam logic [CW-1:0] CAP  = CW'(LINE_CAPACITY);
  localparam logic [CW-1:0] LAST = CW'(LINE_CAPACITY - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] ch;
  logic [CW-1:0]     cursor;
  logic [CW-1:0]     used_len;
  logic [CW-1:0]     tgt;
  logic              hit;
  logic [CW-1:0]     scan_k;
  logic              found;
  logic              acc;
  logic [BYTE_W-1:0] cout;
  logic [CW-1:0]     gap;

  cell_ctl_t         ctl [LINE_CAPACITY];
  logic [BYTE_W-1:0] cell_q [LINE_CAPACITY];

  logic signed [TW-1:0] peek_p;
  logic                 peek_hit;
  logic                 read_hit;
  logic                 edit_ok;

  assign req.ready = (state == ST_IDLE);

  always_comb begin
    peek_p   = $signed(TW'(cursor)) + TW'(req.offset);
    peek_hit = !peek_p[TW-1] && (peek_p < $signed(TW'(used_len)));
    read_hit = TW'(req.position) < TW'(used_len);
  end

  always_comb begin
    case (cmd)
      CMD_INSERT:    edit_ok = used_len < CAP;
      CMD_DELETE:    edit_ok = cursor < used_len;
      CMD_BACKSPACE: edit_ok = cursor != '0;
      CMD_LEFT:      edit_ok = cursor != '0;
      CMD_RIGHT:     edit_ok = cursor < used_len;
      default:       edit_ok = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < LINE_CAPACITY; i++) begin
      ctl[i].din = ch;
      ctl[i].op  = CELL_HOLD;
      if (state == ST_SCAN) begin
        ctl[i].op = CELL_FROM_RIGHT;
      end else if (state == ST_EXEC && edit_ok) begin
        case (cmd)
          CMD_INSERT: begin
            if ((CW+1)'(i) == (CW+1)'(cursor)) begin
              ctl[i].op = CELL_LOAD;
            end else if ((CW+1)'(i) > (CW+1)'(cursor) &&
                         (CW+1)'(i) <= (CW+1)'(used_len)) begin
              ctl[i].op = CELL_FROM_LEFT;
            end
          end
          CMD_DELETE: begin
            if ((CW+1)'(i) >= (CW+1)'(cursor) &&
                (CW+1)'(i) + 1'b1 < (CW+1)'(used_len)) begin
              ctl[i].op = CELL_FROM_RIGHT;
            end
          end
          CMD_BACKSPACE: begin
            if ((CW+1)'(i) + 1'b1 >= (CW+1)'(cursor) &&
                (CW+1)'(i) + 1'b1 < (CW+1)'(used_len)) begin
              ctl[i].op = CELL_FROM_RIGHT;
            end
          end
          default: ctl[i].op = CELL_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < LINE_CAPACITY; g++) begin : g_cell
    lebc_cell u_cell (
      .clk   (clk),
      .ctl   (ctl[g]),
      .left  (cell_q[(g + LINE_CAPACITY - 1) % LINE_CAPACITY]),
      .right (cell_q[(g + 1) % LINE_CAPACITY]),
      .q     (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cursor    <= '0;
      used_len  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != ST_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd   <= req.cmd;
            ch    <= req.char_in;
            state <= ST_EXEC;
            if (req.cmd == CMD_PEEK) begin
              tgt <= peek_p[CW-1:0];
              hit <= peek_hit;
            end else begin
              tgt <= TW'(req.position) < TW'(LINE_CAPACITY) ?
                     CW'(req.position) : '0;
              hit <= read_hit;
            end
          end
        end
        ST_EXEC: begin
          cout   <= '0;
          scan_k <= '0;
          found  <= 1'b0;
          if (cmd inside {CMD_PEEK, CMD_READ_POS, CMD_PREV_DIST, CMD_NEXT_DIST}) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_DONE;
          end
          case (cmd)
            CMD_CLEAR: begin
              acc      <= 1'b1;
              gap      <= '0;
              cursor   <= '0;
              used_len <= '0;
            end
            CMD_INSERT: begin
              acc <= edit_ok;
              gap <= '0;
              if (edit_ok) begin
                cursor   <= cursor + 1'b1;
                used_len <= used_len + 1'b1;
              end
            end
            CMD_DELETE: begin
              acc <= edit_ok;
              gap <= '0;
              if (edit_ok) begin
                used_len <= used_len - 1'b1;
              end
            end
            CMD_BACKSPACE: begin
              acc <= edit_ok;
              gap <= '0;
              if (edit_ok) begin
                cursor   <= cursor - 1'b1;
                used_len <= used_len - 1'b1;
              end
            end
            CMD_LEFT: begin
              acc <= edit_ok;
              gap <= '0;
              if (edit_ok) begin
                cursor <= cursor - 1'b1;
              end
            end
            CMD_RIGHT: begin
              acc <= edit_ok;
              gap <= '0;
              if (edit_ok) begin
                cursor <= cursor + 1'b1;
              end
            end
            CMD_PEEK, CMD_READ_POS: begin
              acc <= 1'b1;
              gap <= '0;
            end
            CMD_PREV_DIST: begin
              acc <= 1'b1;
              gap <= cursor;
            end
            CMD_NEXT_DIST: begin
              acc <= 1'b1;
              gap <= used_len - cursor;
            end
            default: begin
              acc <= 1'b0;
              gap <= '0;
            end
          endcase
        end
        ST_SCAN: begin
          case (cmd)
            CMD_PEEK, CMD_READ_POS: begin
              if (hit && scan_k == tgt) begin
                cout <= cell_q[0];
              end
            end
            CMD_PREV_DIST: begin
              if (scan_k < cursor && cell_q[0] == ch) begin
                gap <= cursor - scan_k - 1'b1;
              end
            end
            CMD_NEXT_DIST: begin
              if (!found && scan_k >= cursor && scan_k < used_len && cell_q[0] == ch) begin
                gap   <= scan_k - cursor;
                found <= 1'b1;
              end
            end
            default: cout <= cout;
          endcase
          scan_k <= scan_k + 1'b1;
          if (scan_k == LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.accepted     <= acc;
            rsp.char_out     <= cout;
            rsp.distance     <= FIELD_W'(gap);
            rsp.cursor_pos   <= FIELD_W'(cursor);
            rsp.line_length  <= FIELD_W'(used_len);
            rsp.at_base      <= cursor == '0;
            rsp.at_end       <= cursor == used_len;
            rsp.is_full_flag <= used_len == CAP;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= used_len) else $error("Cursor is beyond the line length.");

  a_length_in_store: assert property (@(posedge clk) disable iff (rst)
    used_len <= CAP) else $error("Line length exceeds the store capacity.");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_DONE)
    else $error("Result was loaded outside the done state.");

  a_scan_runs_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_k != LAST) |=> state == ST_SCAN)
    else $error("Ring rotation ended early.");

endmodule
`default_nettype wire

FILE: rtl/lebc_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Line edit buffer cell
// One byte of the line; holds, loads, or takes its left or right neighbor.
// ---------------------------------------------------------------------------
module lebc_cell (
  input  wire logic                      clk,
  input  wire lebc_pkg::cell_ctl_t       ctl,
  input  wire logic [lebc_pkg::BYTE_W-1:0] left,
  input  wire logic [lebc_pkg::BYTE_W-1:0] right,
  output logic [lebc_pkg::BYTE_W-1:0]    q
);
  import lebc_pkg::*;

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_HOLD:       q <= q;
      CELL_FROM_LEFT:  q <= left;
      CELL_FROM_RIGHT: q <= right;
      CELL_LOAD:       q <= ctl.din;
      default:         q <= q;
    endcase
  end

endmodule
`default_nettype wire

FILE: bench/line_edit_buffer_with_cursor_tb.sv
// ---------------------------------------------------------------------------
// Line edit buffer with cursor testbench
// Drives edit, cursor and query commands into the line buffer and checks
// every result item against a cycle-free model of the line, its cursor and
// its length. Directed cases cover the edges of the line, a completely full
// line is walked, and then random command streams run with and without
// idle cycles on the command side and stalls on the result side.
// ---------------------------------------------------------------------------
module line_edit_buffer_with_cursor_tb;
  import lebc_pkg::*;

  localparam int CAP          = LINE_CAPACITY_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 470;

  typedef struct packed {
    logic               accepted;
    logic [BYTE_W-1:0]  char_out;
    logic [FIELD_W-1:0] distance;
    logic [FIELD_W-1:0] cursor_pos;
    logic [FIELD_W-1:0] line_length;
    logic               at_base;
    logic               at_end;
    logic               is_full_flag;
  } line_view_t;

  logic clk;
  logic rst;

  lebc_req_if req ();
  lebc_rsp_if rsp ();

  line_edit_buffer_with_cursor #(
    .LINE_CAPACITY(CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  logic [BYTE_W-1:0] line_bytes [CAP];
  int                edit_cursor;
  int                edit_length;
  line_view_t        pending_views [$];
  int                mismatch_count;
  int                cycle_count;
  int                sender_idle_pct;
  int                receiver_stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_edit_buffer_with_cursor_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  function automatic line_view_t next_line_view(input logic [CMD_W-1:0] code,
                                                input logic [BYTE_W-1:0] ch,
                                                input logic signed [OFF_W-1:0] off,
                                                input logic [POS_W-1:0] pos);
    line_view_t v;
    int i;
    int p;
    v = '0;
    case (code)
      CMD_CLEAR: begin
        edit_cursor = 0;
        edit_length = 0;
        v.accepted  = 1'b1;
      end
      CMD_INSERT: begin
        if (edit_length < CAP) begin
          for (i = edit_length; i > edit_cursor; i--) line_bytes[i] = line_bytes[i-1];
          line_bytes[edit_cursor] = ch;
          edit_cursor++;
          edit_length++;
          v.accepted = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (edit_cursor < edit_length) begin
          for (i = edit_cursor; i + 1 < edit_length; i++) line_bytes[i] = line_bytes[i+1];
          edit_length--;
          v.accepted = 1'b1;
        end
      end
      CMD_BACKSPACE: begin
        if (edit_cursor > 0) begin
          for (i = edit_cursor - 1; i + 1 < edit_length; i++) line_bytes[i] = line_bytes[i+1];
          edit_cursor--;
          edit_length--;
          v.accepted = 1'b1;
        end
      end
      CMD_LEFT: begin
        if (edit_cursor > 0) begin
          edit_cursor--;
          v.accepted = 1'b1;
        end
      end
      CMD_RIGHT: begin
        if (edit_cursor < edit_length) begin
          edit_cursor++;
          v.accepted = 1'b1;
        end
      end
      CMD_PEEK: begin
        v.accepted = 1'b1;
        p = edit_cursor + int'(off);
        if (p >= 0 && p < edit_length) v.char_out = line_bytes[p];
      end
      CMD_PREV_DIST: begin
        v.accepted = 1'b1;
        if (edit_cursor > 0) begin
          v.distance = FIELD_W'(edit_cursor);
          for (i = edit_cursor; i > 0; i--) begin
            if (line_bytes[i-1] == ch) begin
              v.distance = FIELD_W'(edit_cursor - i);
              break;
            end
          end
        end
      end
      CMD_NEXT_DIST: begin
        v.accepted = 1'b1;
        v.distance = FIELD_W'(edit_length - edit_cursor);
        for (i = edit_cursor; i < edit_length; i++) begin
          if (line_bytes[i] == ch) begin
            v.distance = FIELD_W'(i - edit_cursor);
            break;
          end
        end
      end
      CMD_READ_POS: begin
        v.accepted = 1'b1;
        if (int'(pos) < edit_length) v.char_out = line_bytes[pos];
      end
      default: begin
      end
    endcase
    v.cursor_pos   = FIELD_W'(edit_cursor);
    v.line_length  = FIELD_W'(edit_length);
    v.at_base      = (edit_cursor == 0);
    v.at_end       = (edit_cursor == edit_length);
    v.is_full_flag = (edit_length == CAP);
    return v;
  endfunction

  // Entered and left at a falling edge; valid stays high for a following item.
  task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [BYTE_W-1:0] ch,
                          input logic signed [OFF_W-1:0] off, input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid    = 1'b1;
    req.cmd      = code;
    req.char_in  = ch;
    req.offset   = off;
    req.position = pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_views.push_back(next_line_view(code, ch, off, pos));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    req.valid = 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] some_line_byte();
    if (edit_length == 0) return BYTE_W'($urandom);
    return line_bytes[$urandom_range(0, edit_length - 1)];
  endfunction

  always @(posedge clk) begin
    line_view_t want;
    bit bad;
    if (!rst && rsp.valid && rsp.ready) begin
      bad = 1'b0;
      if (pending_views.size() == 0) begin
        $error("result item arrived with no expected result pending");
        mismatch_count++;
      end else begin
        want = pending_views.pop_front();
        if (rsp.accepted !== want.accepted)
          $error("accepted: expected %0d, got %0d", want.accepted, rsp.accepted);
        if (rsp.char_out !== want.char_out)
          $error("char_out: expected 0x%02h, got 0x%02h", want.char_out, rsp.char_out);
        if (rsp.distance !== want.distance)
          $error("distance: expected %0d, got %0d", want.distance, rsp.distance);
        if (rsp.cursor_pos !== want.cursor_pos)
          $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, rsp.cursor_pos);
        if (rsp.line_length !== want.line_length)
          $error("line_length: expected %0d, got %0d", want.line_length, rsp.line_length);
        if (rsp.at_base !== want.at_base)
          $error("at_base: expected %0d, got %0d", want.at_base, rsp.at_base);
        if (rsp.at_end !== want.at_end)
          $error("at_end: expected %0d, got %0d", want.at_end, rsp.at_end);
        if (rsp.is_full_flag !== want.is_full_flag)
          $error("is_full_flag: expected %0d, got %0d", want.is_full_flag, rsp.is_full_flag);
        bad = (rsp.accepted !== want.accepted) || (rsp.char_out !== want.char_out) ||
              (rsp.distance !== want.distance) || (rsp.cursor_pos !== want.cursor_pos) ||
              (rsp.line_length !== want.line_length) || (rsp.at_base !== want.at_base) ||
              (rsp.at_end !== want.at_end) || (rsp.is_full_flag !== want.is_full_flag);
        if (bad) mismatch_count++;
      end
    end
  end

  task automatic test_line_edges();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_cmd(CMD_CLEAR,     8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_DELETE,    8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_BACKSPACE, 8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_LEFT,      8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_RIGHT,     8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_PREV_DIST, 8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_NEXT_DIST, 8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_PEEK,      8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_INSERT,    8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_INSERT,    8'hFF, 8'sd0,  6'd0);
    send_cmd(CMD_INSERT,    8'h5A, 8'sd0,  6'd0);
    send_cmd(CMD_LEFT,      8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_LEFT,      8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_PEEK,      8'h00, 8'h80,  6'd0);
    send_cmd(CMD_PEEK,      8'hFF, 8'h7F,  6'd63);
    send_cmd(CMD_PEEK,      8'h00, 8'sd1,  6'd0);
    send_cmd(CMD_PEEK,      8'h00, -8'sd1, 6'd0);
    send_cmd(CMD_READ_POS,  8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_READ_POS,  8'h00, 8'sd0,  6'd63);
    send_cmd(CMD_PREV_DIST, 8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_NEXT_DIST, 8'h5A, 8'sd0,  6'd0);
    send_cmd(CMD_NEXT_DIST, 8'h77, 8'sd0,  6'd0);
    send_cmd(CMD_DELETE,    8'h00, 8'sd0,  6'd0);
    send_cmd(CMD_BACKSPACE, 8'h00, 8'sd0,  6'd0);
    send_cmd(4'hA,          8'hFF, 8'hFF,  6'h3F);
    send_cmd(4'hF,          8'h00, 8'sd0,  6'd0);
    wait_for_results();
  endtask

  task automatic test_full_line();
    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    send_cmd(CMD_CLEAR, 8'h00, 8'sd0, 6'd0);
    repeat (CAP) send_cmd(CMD_INSERT, 8'($urandom), 8'sd0, 6'd0);
    send_cmd(CMD_INSERT,    8'h41, 8'sd0, 6'd0);
    send_cmd(CMD_RIGHT,     8'h00, 8'sd0, 6'd0);
    send_cmd(CMD_READ_POS,  8'h00, 8'sd0, 6'd63);
    send_cmd(CMD_PEEK,      8'h00, -8'sd64, 6'd0);
    repeat (3) send_cmd(CMD_LEFT, 8'h00, 8'sd0, 6'd0);
    send_cmd(CMD_RIGHT,     8'h00, 8'sd0, 6'd0);
    send_cmd(CMD_PEEK,      8'h00, 8'sd1, 6'd0);
    send_cmd(CMD_PREV_DIST, some_line_byte(), 8'sd0, 6'd0);
    send_cmd(CMD_NEXT_DIST, some_line_byte(), 8'sd0, 6'd0);
    wait_for_results();
    send_cmd(CMD_DELETE,    8'h00, 8'sd0, 6'd0);
    send_cmd(CMD_INSERT,    8'hFF, 8'sd0, 6'd0);
    repeat (CAP) send_cmd(CMD_LEFT, 8'h00, 8'sd0, 6'd0);
    send_cmd(CMD_BACKSPACE, 8'h00, 8'sd0, 6'd0);
    send_cmd(CMD_PREV_DIST, 8'hFF, 8'sd0, 6'd0);
    send_cmd(CMD_NEXT_DIST, 8'hFF, 8'sd0, 6'd0);
    send_cmd(CMD_PEEK,      8'h00, 8'sd64, 6'd0);
    send_cmd(CMD_PEEK,      8'h00, 8'sd63, 6'd0);
    send_cmd(CMD_READ_POS,  8'h00, 8'sd0, 6'd0);
    wait_for_results();
  endtask

  // Grow and shrink stretches alternate so the line length swings up and down.
  task automatic test_random_edits(input int n, input int idle, input int stall);
    int k;
    int r;
    bit grow;
    logic [CMD_W-1:0] code;
    logic [BYTE_W-1:0] ch;
    logic signed [OFF_W-1:0] off;
    logic [POS_W-1:0] pos;
    sender_idle_pct    = idle;
    receiver_stall_pct = stall;
    for (k = 0; k < n; k++) begin
      grow = ((k / 60) % 2) == 0;
      r = $urandom_range(0, 199);
      if (r < 1) code = CMD_CLEAR;
      else if (r < (grow ? 90 : 45)) code = CMD_INSERT;
      else if (r < (grow ? 100 : 75)) code = CMD_DELETE;
      else if (r < (grow ? 110 : 105)) code = CMD_BACKSPACE;
      else if (r < 125) code = CMD_LEFT;
      else if (r < 140) code = CMD_RIGHT;
      else if (r < 155) code = CMD_PEEK;
      else if (r < 168) code = CMD_PREV_DIST;
      else if (r < 181) code = CMD_NEXT_DIST;
      else if (r < 195) code = CMD_READ_POS;
      else code = CMD_W'($urandom_range(10, 15));
      case ($urandom_range(0, 2))
        0:       ch = BYTE_W'($urandom);
        1:       ch = 8'h61 + BYTE_W'($urandom_range(0, 3));
        default: ch = some_line_byte();
      endcase
      if ($urandom_range(0, 3) == 0) off = OFF_W'($urandom);
      else off = OFF_W'($urandom_range(0, 2 * edit_length + 2) - edit_length - 1);
      if ($urandom_range(0, 1) == 0 && edit_length > 0) pos = POS_W'($urandom_range(0, edit_length - 1));
      else pos = POS_W'($urandom);
      send_cmd(code, ch, off, pos);
    end
    wait_for_results();
  endtask

  initial begin
    rst                = 1'b1;
    req.valid          = 1'b0;
    req.cmd            = CMD_CLEAR;
    req.char_in        = '0;
    req.offset         = '0;
    req.position       = '0;
    edit_cursor        = 0;
    edit_length        = 0;
    mismatch_count     = 0;
    cycle_count        = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_line_edges();
    test_full_line();
    test_random_edits(RANDOM_ITEMS, 0, 0);
    test_random_edits(RANDOM_ITEMS, 54, 0);
    test_random_edits(RANDOM_ITEMS, 0, 54);
    test_random_edits(RANDOM_ITEMS, 20, 20);

    req.valid = 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("line_edit_buffer_with_cursor_tb: PASS");
    end else begin
      $display("line_edit_buffer_with_cursor_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lebc_pkg.sv
rtl/lebc_if.sv
rtl/lebc_cell.sv
rtl/line_edit_buffer_with_cursor.sv
bench/line_edit_buffer_with_cursor_tb.sv
